/* rtl/core/bat_pkg.sv */
// shared types and constants of the buddy allocator tree
package bat_pkg;

  localparam int unsigned ADDR_W  = 49;
  localparam int unsigned BASE_W  = 48;
  localparam int unsigned ORDER_W = 6;
  localparam int unsigned ORDER_MIN = 1;
  localparam int unsigned ORDER_MAX = 48;

  // node states kept in the tree
  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_PART  = 2'd2,
    ST_FULL  = 2'd3
  } node_st_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic {
    CFG_BASE  = 1'b0,
    CFG_ORDER = 1'b1
  } cfg_idx_t;

  // node store port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // parent state from its two children, merging free buddies
  function automatic node_st_t settle(input node_st_t l, input node_st_t r);
    logic lf;
    logic rf;
    lf = (l == ST_ALLOC) || (l == ST_FULL);
    rf = (r == ST_ALLOC) || (r == ST_FULL);
    if (l == ST_FREE && r == ST_FREE) begin
      return ST_FREE;
    end else if (lf && rf) begin
      return ST_FULL;
    end
    return ST_PART;
  endfunction

endpackage

/* rtl/core/buddy_allocator_tree.sv */
// buddy allocator top level: sequencer, shared size and address unit, result register
//
// buddy allocator over a pool of 2^pool_order bytes, held as an implicit binary tree of
// node states (root 0, children 2i+1 and 2i+2). pulse start while busy is low to hand in
// one word: an allocate request (size rounded up to a power of two, 0 counts as 1) or a
// free request by address. busy stays high until the result is shown: out_valid is high
// for exactly one cycle with granted, block address and the allocated and free byte
// totals; the receiver cannot stall it and must take it in that cycle. a free outside
// the pool goes straight to the result. allocation first rounds the size by doubling
// (up to 48 doublings), then every node visited is read, evaluated and stepped back
// from, and every split node on the way back is settled by two reads and a write, so a
// failing depth-first search over a fully split, fragmented tree sets the worst case.
// the root lives in a flip-flop and comes out of reset free; the rest of the store is
// written before it is read, so no clearing pass is needed. configuration writes take
// effect at once, so make them only while idle.
module buddy_allocator_tree #(
  parameter int unsigned MAX_DEPTH       = 10,
  parameter int unsigned MIN_SPLIT_BYTES = 2560
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [bat_pkg::ADDR_W-1:0]    in_request_bytes,
  input  logic [bat_pkg::ADDR_W-1:0]    in_free_address,
  output logic                          out_valid,
  output logic                          out_granted,
  output logic [bat_pkg::ADDR_W-1:0]    out_block_address,
  output logic [bat_pkg::ADDR_W-1:0]    out_allocated_bytes,
  output logic [bat_pkg::ADDR_W-1:0]    out_free_bytes,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bat_pkg::BASE_W-1:0]    cfg_wdata
);

  localparam int unsigned AW    = bat_pkg::ADDR_W;
  localparam int unsigned NODE_W = MAX_DEPTH + 1;
  localparam int unsigned DEP_W = $clog2(MAX_DEPTH + 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_ROUND  = 11'b000_0000_0010,
    S_READ   = 11'b000_0000_0100,
    S_EVAL   = 11'b000_0000_1000,
    S_SPLIT1 = 11'b000_0001_0000,
    S_SPLIT2 = 11'b000_0010_0000,
    S_UP     = 11'b000_0100_0000,
    S_SETL   = 11'b000_1000_0000,
    S_SETR   = 11'b001_0000_0000,
    S_SETW   = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [bat_pkg::BASE_W-1:0] base_r, base_nxt;
  logic [bat_pkg::ORDER_W-1:0] order_r, order_nxt;
  logic [AW-1:0]              total_r, total_nxt;
  bat_pkg::node_st_t          root_r, root_nxt;
  logic                       mode_r, mode_nxt;
  logic [AW-1:0]              req_r, req_nxt;   // requested size as handed in
  logic [AW-1:0]              off_r, off_nxt;   // pool offset of block or free target
  logic [AW-1:0]              start_r, start_nxt;
  logic [DEP_W-1:0]           depth_r, depth_nxt;
  logic [NODE_W-1:0]          idx_r, idx_nxt;
  logic                       ok_r, ok_nxt;
  bat_pkg::node_st_t          left_r, left_nxt;
  logic [AW-1:0]              bytes_r, bytes_nxt;

  logic                       ovalid_r, ovalid_nxt;
  logic                       ogrant_r, ogrant_nxt;
  logic [AW-1:0]              oaddr_r, oaddr_nxt;
  logic [AW-1:0]              oalloc_r, oalloc_nxt;
  logic [AW-1:0]              ofree_r, ofree_nxt;

  // node store port
  bat_pkg::mem_ctl_t          mctl;
  logic [NODE_W-1:0]          mrd_addr;
  logic [NODE_W-1:0]          mwr_addr;
  bat_pkg::node_st_t          mwr_data;
  bat_pkg::node_st_t          mrd_data;

  // shared size unit and helpers
  logic [bat_pkg::ORDER_W-1:0] ord_eff;
  logic [AW-1:0]              pool;
  logic [AW-1:0]              size_w;
  logic [AW-1:0]              half_w;
  logic [NODE_W-1:0]          left_idx;
  logic [NODE_W-1:0]          parent_idx;
  logic                       is_root;
  bat_pkg::node_st_t          cur_st;
  logic [AW:0]                add_sum;
  logic [AW-1:0]              fa_off;

  always_comb begin
    priority if (order_r < bat_pkg::ORDER_W'(bat_pkg::ORDER_MIN)) begin
      ord_eff = bat_pkg::ORDER_W'(bat_pkg::ORDER_MIN);
    end else if (order_r > bat_pkg::ORDER_W'(bat_pkg::ORDER_MAX)) begin
      ord_eff = bat_pkg::ORDER_W'(bat_pkg::ORDER_MAX);
    end else begin
      ord_eff = order_r;
    end
  end

  assign pool       = AW'(1) << ord_eff;
  assign size_w     = pool >> depth_r;
  assign half_w     = size_w >> 1;
  assign left_idx   = {idx_r[NODE_W-2:0], 1'b1};
  assign parent_idx = (idx_r - NODE_W'(1)) >> 1;
  assign is_root    = (idx_r == '0);
  assign cur_st     = is_root ? root_r : mrd_data;
  assign add_sum    = {1'b0, total_r} + {1'b0, size_w};
  assign fa_off     = in_free_address - {1'b0, base_r};

  always_comb begin
    state_nxt  = state_r;
    base_nxt   = base_r;
    order_nxt  = order_r;
    total_nxt  = total_r;
    root_nxt   = root_r;
    mode_nxt   = mode_r;
    req_nxt    = req_r;
    off_nxt    = off_r;
    start_nxt  = start_r;
    depth_nxt  = depth_r;
    idx_nxt    = idx_r;
    ok_nxt     = ok_r;
    left_nxt   = left_r;
    bytes_nxt  = bytes_r;
    ovalid_nxt = 1'b0;
    ogrant_nxt = ogrant_r;
    oaddr_nxt  = oaddr_r;
    oalloc_nxt = oalloc_r;
    ofree_nxt  = ofree_r;
    mctl       = '0;
    mrd_addr   = idx_r;
    mwr_addr   = idx_r;
    mwr_data   = bat_pkg::ST_FREE;

    // configuration port
    if (cfg_we) begin
      unique case (bat_pkg::cfg_idx_t'(cfg_index))
        bat_pkg::CFG_BASE:  base_nxt  = cfg_wdata;
        bat_pkg::CFG_ORDER: order_nxt = cfg_wdata[bat_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = in_op;
          ok_nxt    = 1'b0;
          idx_nxt   = '0;
          depth_nxt = '0;
          start_nxt = '0;
          if (in_op == bat_pkg::OP_ALLOC) begin
            req_nxt   = in_request_bytes;
            bytes_nxt = AW'(1);
            state_nxt = (in_request_bytes > pool) ? S_DONE : S_ROUND;
          end else begin
            off_nxt = fa_off;
            if (in_free_address >= {1'b0, base_r} && fa_off < pool) begin
              state_nxt = S_READ;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      // one doubling per cycle up to the request size
      S_ROUND: begin
        if (bytes_r < req_r) begin
          bytes_nxt = bytes_r << 1;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        mctl.rd_en = 1'b1;
        mrd_addr   = idx_r;
        state_nxt  = S_EVAL;
      end
      S_EVAL: begin
        if (mode_r == bat_pkg::OP_ALLOC) begin
          unique case (cur_st)
            bat_pkg::ST_ALLOC, bat_pkg::ST_FULL: begin
              ok_nxt    = 1'b0;
              state_nxt = S_UP;
            end
            bat_pkg::ST_PART: begin
              idx_nxt   = left_idx;
              depth_nxt = depth_r + DEP_W'(1);
              state_nxt = S_READ;
            end
            default: begin
              priority if (bytes_r > size_w) begin
                ok_nxt    = 1'b0;
                state_nxt = S_UP;
              end else if (half_w >= bytes_r && size_w > AW'(MIN_SPLIT_BYTES) &&
                           depth_r < DEP_W'(MAX_DEPTH)) begin
                // split: mark this node, then clear both children
                if (is_root) begin
                  root_nxt = bat_pkg::ST_PART;
                end else begin
                  mctl.wr_en = 1'b1;
                  mwr_data   = bat_pkg::ST_PART;
                end
                state_nxt = S_SPLIT1;
              end else begin
                if (is_root) begin
                  root_nxt = bat_pkg::ST_ALLOC;
                end else begin
                  mctl.wr_en = 1'b1;
                  mwr_data   = bat_pkg::ST_ALLOC;
                end
                total_nxt = add_sum[AW] ? '1 : add_sum[AW-1:0];
                off_nxt   = start_r;
                ok_nxt    = 1'b1;
                state_nxt = S_UP;
              end
            end
          endcase
        end else begin
          unique case (cur_st)
            bat_pkg::ST_PART, bat_pkg::ST_FULL: begin
              depth_nxt = depth_r + DEP_W'(1);
              if (off_r < start_r + half_w) begin
                idx_nxt = left_idx;
              end else begin
                idx_nxt   = left_idx + NODE_W'(1);
                start_nxt = start_r + half_w;
              end
              state_nxt = S_READ;
            end
            bat_pkg::ST_ALLOC: begin
              if (start_r == off_r) begin
                if (is_root) begin
                  root_nxt = bat_pkg::ST_FREE;
                end else begin
                  mctl.wr_en = 1'b1;
                  mwr_data   = bat_pkg::ST_FREE;
                end
                total_nxt = (total_r >= size_w) ? total_r - size_w : '0;
                ok_nxt    = 1'b1;
              end else begin
                ok_nxt = 1'b0;
              end
              state_nxt = S_UP;
            end
            default: begin
              ok_nxt    = 1'b0;
              state_nxt = S_UP;
            end
          endcase
        end
      end
      S_SPLIT1: begin
        mctl.wr_en = 1'b1;
        mwr_addr   = left_idx;
        mwr_data   = bat_pkg::ST_FREE;
        state_nxt  = S_SPLIT2;
      end
      S_SPLIT2: begin
        mctl.wr_en = 1'b1;
        mwr_addr   = left_idx + NODE_W'(1);
        mwr_data   = bat_pkg::ST_FREE;
        idx_nxt    = left_idx;
        depth_nxt  = depth_r + DEP_W'(1);
        state_nxt  = S_READ;
      end
      // return one level: try the right buddy after a failed left, else settle parent
      S_UP: begin
        if (is_root) begin
          state_nxt = S_DONE;
        end else if (mode_r == bat_pkg::OP_ALLOC && !ok_r && idx_r[0]) begin
          idx_nxt   = idx_r + NODE_W'(1);
          start_nxt = start_r + size_w;
          state_nxt = S_READ;
        end else begin
          if (!idx_r[0]) begin
            start_nxt = start_r - size_w;
          end
          idx_nxt   = parent_idx;
          depth_nxt = depth_r - DEP_W'(1);
          state_nxt = S_SETL;
        end
      end
      S_SETL: begin
        mctl.rd_en = 1'b1;
        mrd_addr   = left_idx;
        state_nxt  = S_SETR;
      end
      S_SETR: begin
        mctl.rd_en = 1'b1;
        mrd_addr   = left_idx + NODE_W'(1);
        left_nxt   = mrd_data;
        state_nxt  = S_SETW;
      end
      S_SETW: begin
        if (is_root) begin
          root_nxt = bat_pkg::settle(left_r, mrd_data);
        end else begin
          mctl.wr_en = 1'b1;
          mwr_data   = bat_pkg::settle(left_r, mrd_data);
        end
        state_nxt = S_UP;
      end
      S_DONE: begin
        ovalid_nxt = 1'b1;
        ogrant_nxt = ok_r;
        oaddr_nxt  = ok_r ? AW'({1'b0, base_r} + off_r) : '0;
        oalloc_nxt = total_r;
        ofree_nxt  = (pool >= total_r) ? pool - total_r : '0;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      base_r   <= '0;
      order_r  <= bat_pkg::ORDER_W'(20);
      total_r  <= '0;
      root_r   <= bat_pkg::ST_FREE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      base_r   <= base_nxt;
      order_r  <= order_nxt;
      total_r  <= total_nxt;
      root_r   <= root_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // working and result words, no reset needed
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    req_r    <= req_nxt;
    off_r    <= off_nxt;
    start_r  <= start_nxt;
    depth_r  <= depth_nxt;
    idx_r    <= idx_nxt;
    ok_r     <= ok_nxt;
    left_r   <= left_nxt;
    bytes_r  <= bytes_nxt;
    ogrant_r <= ogrant_nxt;
    oaddr_r  <= oaddr_nxt;
    oalloc_r <= oalloc_nxt;
    ofree_r  <= ofree_nxt;
  end

  bat_node_mem #(
    .AW(NODE_W)
  ) u_node_mem (
    .clk     (clk),
    .ctl     (mctl),
    .rd_addr (mrd_addr),
    .wr_addr (mwr_addr),
    .wr_data (mwr_data),
    .rd_data (mrd_data)
  );

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = ovalid_r;
  assign out_granted         = ogrant_r;
  assign out_block_address   = oaddr_r;
  assign out_allocated_bytes = oalloc_r;
  assign out_free_bytes      = ofree_r;

`ifndef SYNTHESIS
  // a word handed in keeps the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // the result strobe shows only with the block already free again, right after it was busy
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a word");

  // a refused word reports no address
  a_refused_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_granted) |-> (out_block_address == '0))
    else $error("address on a refused word");
`endif

endmodule

/* rtl/core/bat_node_mem.sv */
// node state store: one write and one registered read per cycle
module bat_node_mem #(
  parameter int unsigned AW = 11
) (
  input  logic                clk,
  input  bat_pkg::mem_ctl_t   ctl,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  bat_pkg::node_st_t   wr_data,
  output bat_pkg::node_st_t   rd_data
);

  bat_pkg::node_st_t mem [2**AW];
  bat_pkg::node_st_t rd_q_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

/* tb/buddy_allocator_tree_checker.sv */
// checker for the buddy allocator tree: own predictor, expected result queue, comparison
`timescale 1ns / 100ps
module buddy_allocator_tree_checker #(
  parameter int unsigned MAX_DEPTH       = 10,
  parameter int unsigned MIN_SPLIT_BYTES = 2560
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_op,
  input  logic [bat_pkg::ADDR_W-1:0] in_request_bytes,
  input  logic [bat_pkg::ADDR_W-1:0] in_free_address,
  input  logic                       out_valid,
  input  logic                       out_granted,
  input  logic [bat_pkg::ADDR_W-1:0] out_block_address,
  input  logic [bat_pkg::ADDR_W-1:0] out_allocated_bytes,
  input  logic [bat_pkg::ADDR_W-1:0] out_free_bytes,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bat_pkg::BASE_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending,
  output int                         grant_count
);
  import bat_pkg::*;

  localparam int unsigned NODES = (1 << (MAX_DEPTH + 1)) - 1;
  localparam logic [63:0] SAT49 = 64'h1_FFFF_FFFF_FFFF;

  typedef struct {
    logic              granted;
    logic [ADDR_W-1:0] block_address;
    logic [ADDR_W-1:0] allocated_bytes;
    logic [ADDR_W-1:0] free_bytes;
  } outcome_t;

  node_st_t          tree [0:NODES-1];
  logic [63:0]       bytes_in_use;
  logic [BASE_W-1:0] base_reg;
  logic [ORDER_W-1:0] order_reg;
  outcome_t          outcome_q [$];

  function automatic logic [63:0] pool_bytes();
    int unsigned o;
    o = order_reg;
    if (o < ORDER_MIN) o = ORDER_MIN;
    if (o > ORDER_MAX) o = ORDER_MAX;
    return 64'd1 << o;
  endfunction

  function automatic bit is_taken(node_st_t s);
    return (s == ST_ALLOC) || (s == ST_FULL);
  endfunction

  // parent state from its children
  function automatic void regroup(int unsigned i);
    node_st_t l;
    node_st_t r;
    l = tree[2*i+1];
    r = tree[2*i+2];
    if (l == ST_FREE && r == ST_FREE) tree[i] = ST_FREE;
    else if (is_taken(l) && is_taken(r)) tree[i] = ST_FULL;
    else tree[i] = ST_PART;
  endfunction

  function automatic bit grab_block(input int unsigned i, input int unsigned dep,
                                    input logic [63:0] st, input logic [63:0] sz,
                                    input logic [63:0] want, output logic [63:0] off);
    node_st_t s;
    bit ok;
    s   = tree[i];
    off = '0;
    if (is_taken(s)) return 1'b0;
    if (s == ST_PART) begin
      ok = grab_block(2*i+1, dep+1, st, sz >> 1, want, off);
      if (!ok) ok = grab_block(2*i+2, dep+1, st + (sz >> 1), sz >> 1, want, off);
      regroup(i);
      return ok;
    end
    if (want > sz) return 1'b0;
    // split while the lower half still holds the request
    if ((sz >> 1) >= want && sz > MIN_SPLIT_BYTES && dep < MAX_DEPTH) begin
      tree[2*i+1] = ST_FREE;
      tree[2*i+2] = ST_FREE;
      tree[i]     = ST_PART;
      ok = grab_block(2*i+1, dep+1, st, sz >> 1, want, off);
      regroup(i);
      return ok;
    end
    tree[i] = ST_ALLOC;
    bytes_in_use = bytes_in_use + sz;
    if (bytes_in_use > SAT49) bytes_in_use = SAT49;
    off = st;
    return 1'b1;
  endfunction

  function automatic bit drop_block(int unsigned i, logic [63:0] st, logic [63:0] sz,
                                    logic [63:0] off);
    node_st_t s;
    bit ok;
    s = tree[i];
    if (s == ST_PART || s == ST_FULL) begin
      if (off < st + (sz >> 1)) ok = drop_block(2*i+1, st, sz >> 1, off);
      else ok = drop_block(2*i+2, st + (sz >> 1), sz >> 1, off);
      regroup(i);
      return ok;
    end
    if (s == ST_ALLOC && st == off) begin
      tree[i] = ST_FREE;
      bytes_in_use = (bytes_in_use >= sz) ? bytes_in_use - sz : 64'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic outcome_t predict_word(logic op, logic [63:0] req, logic [63:0] fa);
    outcome_t    o;
    logic [63:0] pool;
    logic [63:0] p;
    logic [63:0] off;
    logic [63:0] addr;
    bit ok;
    pool = pool_bytes();
    ok   = 1'b0;
    addr = '0;
    if (op == OP_ALLOC) begin
      if (req <= pool) begin
        p = 64'd1;
        while (p < req) p = p << 1;
        ok = grab_block(0, 0, 64'd0, pool, p, off);
        if (ok) addr = base_reg + off;
      end
    end else if (fa >= base_reg && fa - base_reg < pool) begin
      ok = drop_block(0, 64'd0, pool, fa - base_reg);
      if (ok) addr = fa;
    end
    o.granted         = ok;
    o.block_address   = addr[ADDR_W-1:0];
    o.allocated_bytes = bytes_in_use[ADDR_W-1:0];
    o.free_bytes      = (pool >= bytes_in_use) ? ADDR_W'(pool - bytes_in_use) : '0;
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      tree[0]      = ST_FREE;
      bytes_in_use = '0;
      base_reg     = '0;
      order_reg    = 6'd20;
      outcome_q.delete();
      fail_count   = 0;
      grant_count  = 0;
    end else begin
      if (out_valid) begin
        if (outcome_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: result word with nothing expected", $realtime);
        end else begin
          want = outcome_q.pop_front();
          if (out_granted) grant_count++;
          if (out_granted !== want.granted || out_block_address !== want.block_address ||
              out_allocated_bytes !== want.allocated_bytes ||
              out_free_bytes !== want.free_bytes) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp g%0b a%h u%h f%h got g%0b a%h u%h f%h", $realtime,
                       want.granted, want.block_address, want.allocated_bytes,
                       want.free_bytes, out_granted, out_block_address,
                       out_allocated_bytes, out_free_bytes);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_BASE) base_reg = cfg_wdata;
        else order_reg = cfg_wdata[ORDER_W-1:0];
      end
      if (start && !busy)
        outcome_q.push_back(predict_word(in_op, 64'(in_request_bytes), 64'(in_free_address)));
    end
    pending = outcome_q.size();
  end

endmodule

/* tb/tb_buddy_allocator_tree.sv */
// testbench top for the buddy allocator tree: stimulus, configuration phases, verdict
`timescale 1ns / 100ps
module tb_buddy_allocator_tree;
  import bat_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 60000000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_op = OP_ALLOC;
  logic [ADDR_W-1:0] in_request_bytes = '0;
  logic [ADDR_W-1:0] in_free_address = '0;
  logic              out_valid;
  logic              out_granted;
  logic [ADDR_W-1:0] out_block_address;
  logic [ADDR_W-1:0] out_allocated_bytes;
  logic [ADDR_W-1:0] out_free_bytes;
  logic              cfg_we = 1'b0;
  logic              cfg_index = CFG_BASE;
  logic [BASE_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int grant_count;
  int words_sent;
  int phases_run;
  int cycle_count;

  // addresses of blocks this side believes are live
  logic [ADDR_W-1:0] live_q [$];
  logic [5:0]        cur_order;
  bit                no_gaps;

  always #4 clk = ~clk;

  buddy_allocator_tree u_top (
    .clk, .rst_n, .start, .busy, .in_op, .in_request_bytes, .in_free_address,
    .out_valid, .out_granted, .out_block_address, .out_allocated_bytes, .out_free_bytes,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  buddy_allocator_tree_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_op, .in_request_bytes, .in_free_address,
    .out_valid, .out_granted, .out_block_address, .out_allocated_bytes, .out_free_bytes,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending, .grant_count
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand49();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // one word: random gap, start held until taken, then wait for its result
  task automatic send_word(logic op, logic [ADDR_W-1:0] req, logic [ADDR_W-1:0] fa);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    repeat (gap) @(posedge clk);
    @(posedge clk);
    start            <= 1'b1;
    in_op            <= op;
    in_request_bytes <= req;
    in_free_address  <= fa;
    do @(posedge clk); while (!(start && !busy));
    start <= 1'b0;
    do @(posedge clk); while (!out_valid);
    words_sent++;
    if (out_granted && op == OP_ALLOC) live_q.push_back(out_block_address);
  endtask

  task automatic free_live(int idx);
    logic [ADDR_W-1:0] a;
    a = live_q[idx];
    live_q.delete(idx);
    send_word(OP_FREE, rand49(), a);
  endtask

  // registers only change with the block idle
  task automatic write_reg(cfg_idx_t idx, logic [BASE_W-1:0] val);
    wait (pending == 0);
    while (busy) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_ORDER) cur_order = val[5:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // allocation size scaled to the pool, with the odd oversized or huge one
  function automatic logic [ADDR_W-1:0] pick_size();
    int unsigned o;
    int unsigned sh;
    logic [63:0] lim;
    o = (cur_order < ORDER_MIN) ? ORDER_MIN : (cur_order > ORDER_MAX) ? ORDER_MAX : cur_order;
    if ($urandom_range(0, 19) == 0) return rand49() & 49'h1_FFFF_FFFF_FFFF;
    sh  = $urandom_range(0, (o > 12) ? 12 : o);
    sh  = (o - sh > 14) ? o - $urandom_range(2, 14) : sh;
    lim = (64'd1 << o) >> sh;
    return ADDR_W'(({$urandom, $urandom} % (lim + 1)));
  endfunction

  task automatic run_phase(int n);
    int k;
    int r;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (k == n / 2) no_gaps = ~no_gaps;
      if (r < 55 || live_q.size() == 0) send_word(OP_ALLOC, pick_size(), rand49());
      else if (r < 85) free_live($urandom_range(0, live_q.size() - 1));
      else if (r < 93) send_word(OP_FREE, pick_size(), rand49());
      else send_word(OP_FREE, '0, live_q[$urandom_range(0, live_q.size() - 1)] + 1'b1);
    end
    // give most blocks back so the next setting starts mostly clean
    while (live_q.size() > 0 && $urandom_range(0, 9) != 0) free_live(0);
    phases_run++;
  endtask

  initial begin
    int p;
    logic [ADDR_W-1:0] a;
    cur_order = 6'd20;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: size extremes, rounding, oversize, unknown frees, whole pool
    send_word(OP_ALLOC, '0, '0);
    send_word(OP_ALLOC, 49'd1, '0);
    send_word(OP_ALLOC, 49'd3000, '0);
    send_word(OP_ALLOC, 49'd4097, '0);
    send_word(OP_ALLOC, 49'h1_0000_0000_0000, '0);
    send_word(OP_ALLOC, 49'h1_FFFF_FFFF_FFFF, '0);
    send_word(OP_ALLOC, 49'h10_0001, '0);
    send_word(OP_ALLOC, 49'h10_0000, '0);
    send_word(OP_FREE, '0, 49'h1_FFFF_FFFF_FFFF);
    send_word(OP_FREE, '0, 49'h10_0000);
    send_word(OP_FREE, '0, live_q[1] + 49'd4);
    a = live_q[0];
    free_live(0);
    send_word(OP_FREE, '0, a);
    while (live_q.size() > 0) free_live(live_q.size() - 1);
    send_word(OP_ALLOC, 49'h10_0000, '0);
    // pool order shrinks under a live block
    write_reg(CFG_ORDER, 48'd12);
    send_word(OP_ALLOC, 49'd1, '0);
    while (live_q.size() > 0) free_live(0);
    write_reg(CFG_BASE, 48'hFFFF_FFFF_FFFF);
    send_word(OP_FREE, '0, 49'd5);
    send_word(OP_ALLOC, 49'd4096, '0);
    send_word(OP_ALLOC, 49'd1, '0);
    while (live_q.size() > 0) free_live(0);

    // random phases across settings, extremes included
    for (p = 0; p < 9; p++) begin
      case (p)
        0: begin write_reg(CFG_BASE, '0);                   write_reg(CFG_ORDER, 48'd20); end
        1: begin write_reg(CFG_BASE, 48'hFFFF_FFFF_FFFF);   write_reg(CFG_ORDER, 48'd1);  end
        2: begin write_reg(CFG_BASE, 48'd123456789);        write_reg(CFG_ORDER, 48'd24); end
        3: begin write_reg(CFG_BASE, '0);                   write_reg(CFG_ORDER, 48'd0);  end
        4: begin write_reg(CFG_BASE, 48'h8000_0000_0000);   write_reg(CFG_ORDER, 48'd48); end
        5: begin
          write_reg(CFG_BASE, BASE_W'({$urandom, $urandom}));
          write_reg(CFG_ORDER, 48'd63);
        end
        6: begin
          write_reg(CFG_BASE, BASE_W'({$urandom, $urandom}));
          write_reg(CFG_ORDER, 48'd16);
        end
        7: begin write_reg(CFG_BASE, 48'h5555_AAAA_5555);   write_reg(CFG_ORDER, 48'd22); end
        default: begin write_reg(CFG_BASE, 48'd4096);       write_reg(CFG_ORDER, 48'd13); end
      endcase
      live_q.delete();
      run_phase(105);
      // hold off until the block has nothing in flight
      if (p == 4) wait (pending == 0);
    end

    wait (pending == 0);
    repeat (50) @(posedge clk);
    $display("%0d words over %0d random settings, %0d granted, base and order extremes hit",
             words_sent, phases_run, grant_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
